>>> sv/tdoa_cross_correlation_unit_defines.svh
// assertion macros for the tdoa correlation unit
`ifndef TDOA_CROSS_CORRELATION_UNIT_DEFINES_SVH
`define TDOA_CROSS_CORRELATION_UNIT_DEFINES_SVH

// checked after reset only
`define TDOA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tdoa assertion failed");

// checked at every edge, reset included
`define TDOA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tdoa assertion failed");

`endif

>>> sv/tdoa_pkg.sv
package tdoa_pkg;

    localparam int MAX_SAMPLES_DEF  = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int ALPHA_W  = 16;
    localparam int PERIOD_W = 28;
    localparam int MAXLAG_W = 12;
    localparam int MINOV_W  = 13;
    localparam int MINC_W   = 16;
    localparam int CFG_W    = 28;
    localparam int IDX_W    = 3;

    localparam int LAG_W    = 13;
    localparam int DELAY_W  = 42;
    localparam int CORR_W   = 16;
    localparam int SCORE_W  = 17;
    localparam int Q_W      = 16;

    localparam int LAG_LSB     = 0;
    localparam int DELAY_LSB   = LAG_LSB + LAG_W;
    localparam int CORR_LSB    = DELAY_LSB + DELAY_W;
    localparam int OUT_TDATA_W = ((CORR_LSB + CORR_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] REG_HP_ALPHA      = 3'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_LAG       = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_OVERLAP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_CORR      = 3'd4;

    localparam logic [ALPHA_W-1:0]  HP_ALPHA_RST      = 16'd61510;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 28'd22906492;
    localparam logic [MAXLAG_W-1:0] MAX_LAG_RST       = 12'd1023;
    localparam logic [MINOV_W-1:0]  MIN_OVERLAP_RST   = 13'd100;
    localparam logic [MINC_W-1:0]   MIN_CORR_RST      = 16'd22938;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_sts;

endpackage

>>> sv/tdoa_arith.sv
module tdoa_arith #(
    parameter int MUL_W = 62
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tdoa_pkg::t_arith_ctl        i_ctl,
    input  logic [MUL_W-1:0]            i_a,
    input  logic [MUL_W-1:0]            i_b,
    input  logic [2*MUL_W-1:0]          i_wide,
    output tdoa_pkg::t_arith_sts        o_sts,
    output logic [2*MUL_W-1:0]          o_prod,
    output logic [MUL_W-1:0]            o_root,
    output logic [tdoa_pkg::Q_W-1:0]    o_quot
);

    localparam int P_W = 2 * MUL_W;
    localparam int R_W = MUL_W + 2;
    localparam int C_W = $clog2(MUL_W + 1);

    logic                   r_busy;
    logic                   r_done;
    tdoa_pkg::t_op          r_op;
    logic [C_W-1:0]         r_cnt;
    logic [P_W-1:0]         r_acc;
    logic [P_W-1:0]         r_x;
    logic [MUL_W-1:0]       r_y;
    logic [R_W-1:0]         r_rem;
    logic [tdoa_pkg::Q_W-1:0] r_q;

    logic [R_W-1:0] rem_t;
    logic [R_W-1:0] trial;
    logic           sq_ge;
    logic           div_ge;

    assign rem_t  = {r_rem[MUL_W-1:0], r_x[P_W-1 -: 2]};
    assign trial  = {r_y, 2'b01};
    assign sq_ge  = (rem_t >= trial);
    assign div_ge = (r_rem >= {2'b00, r_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= tdoa_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_op   <= i_ctl.op;
                r_busy <= 1'b1;
                case (i_ctl.op)
                    tdoa_pkg::OP_MUL: begin
                        r_acc <= '0;
                        r_x   <= {{MUL_W{1'b0}}, i_a};
                        r_y   <= i_b;
                        r_cnt <= C_W'(MUL_W);
                    end
                    tdoa_pkg::OP_SQRT: begin
                        r_x   <= i_wide;
                        r_y   <= '0;
                        r_rem <= '0;
                        r_cnt <= C_W'(MUL_W);
                    end
                    tdoa_pkg::OP_DIV: begin
                        r_rem <= {2'b00, i_a};
                        r_y   <= i_b;
                        r_q   <= '0;
                        r_cnt <= C_W'(tdoa_pkg::Q_W);
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_cnt  <= '0;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    tdoa_pkg::OP_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[P_W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[MUL_W-1:1]};
                    end
                    tdoa_pkg::OP_SQRT: begin
                        r_rem <= sq_ge ? (rem_t - trial) : rem_t;
                        r_y   <= {r_y[MUL_W-2:0], sq_ge};
                        r_x   <= {r_x[P_W-3:0], 2'b00};
                    end
                    tdoa_pkg::OP_DIV: begin
                        r_q   <= {r_q[tdoa_pkg::Q_W-2:0], div_ge};
                        r_rem <= div_ge ? {r_rem - {2'b00, r_y}} << 1 : r_rem << 1;
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;
    assign o_root     = r_y;
    assign o_quot     = r_q;

endmodule

>>> sv/tdoa_cross_correlation_unit.sv
// channel   dir  handshake                 payload
// s_*       in   i_s_tvalid / o_s_tready   tdata left, right; tlast last_pair
// m_*       out  o_m_tvalid / i_m_tready   tdata lag, delay, corr; tuser found
// cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// pairs load one per cycle; a last pair starts the lag search, ready low
// scored lag: sums over the overlap, 7 products, one root and one divide
// on the shared arith unit with MW-bit operands, then the check and the step
// (MW = 2*store width + 2*count bits)
// skipped lag: S_LAG then S_NEXT; the shared arith unit sets the search time
// synchronous active-low reset; stores need no clearing
// a result waiting on i_m_tready holds the search end, loading resumes after it
module tdoa_cross_correlation_unit #(
    parameter int MAX_SAMPLES  = tdoa_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_WIDTH = tdoa_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // best_lag, delay, correlation
    output logic [tdoa_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // found
    output logic                              o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [tdoa_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [tdoa_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int ST_W  = SW + 2;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int PRD_W = 2 * ST_W;
    localparam int ACC_W = PRD_W + CNT_W;
    localparam int MW    = ACC_W + CNT_W;
    localparam int P_W   = 2 * MW;
    localparam int T_W   = P_W + 1;
    localparam int D_W   = P_W + 2;
    localparam int CW    = (CNT_W > tdoa_pkg::MINOV_W) ? CNT_W : tdoa_pkg::MINOV_W;
    localparam int LW    = tdoa_pkg::LAG_W;

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0000000000001,
        S_START = 13'b0000000000010,
        S_LAG   = 13'b0000000000100,
        S_ACC   = 13'b0000000001000,
        S_MGO   = 13'b0000000010000,
        S_MWAIT = 13'b0000000100000,
        S_VCHK  = 13'b0000001000000,
        S_SGO   = 13'b0000010000000,
        S_SWAIT = 13'b0000100000000,
        S_DGO   = 13'b0001000000000,
        S_DWAIT = 13'b0010000000000,
        S_NEXT  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    function automatic logic signed [ST_W-1:0] hp_filter(
        input logic [tdoa_pkg::ALPHA_W-1:0] alpha,
        input logic signed [SW-1:0]         x,
        input logic signed [SW-1:0]         prev
    );
        logic signed [SW:0]     d;
        logic signed [SW+17:0]  p;
        logic [SW+17:0]         mag;
        logic [SW+17:0]         rnd;
        logic signed [ST_W-1:0] y;
        d   = {x[SW-1], x} - {prev[SW-1], prev};
        p   = $signed({1'b0, alpha}) * d;
        mag = p[SW+17] ? -p : p;
        rnd = (mag + {{(SW+2){1'b0}}, 16'h8000}) >> 16;
        y   = rnd[ST_W-1:0];
        return p[SW+17] ? -y : y;
    endfunction

    t_state r_state, n_state;

    logic [tdoa_pkg::ALPHA_W-1:0]  r_hp_alpha;
    logic [tdoa_pkg::PERIOD_W-1:0] r_period;
    logic [tdoa_pkg::MAXLAG_W-1:0] r_max_lag;
    logic [tdoa_pkg::MINOV_W-1:0]  r_min_overlap;
    logic [tdoa_pkg::MINC_W-1:0]   r_min_corr;

    logic signed [ST_W-1:0] r_left_mem  [MAX_SAMPLES];
    logic signed [ST_W-1:0] r_right_mem [MAX_SAMPLES];

    logic signed [SW-1:0]   r_prev_l, r_prev_r;
    logic [CNT_W-1:0]       r_cnt;
    logic [tdoa_pkg::MAXLAG_W-1:0] r_bound;
    logic signed [LW-1:0]   r_lag;
    logic [CNT_W-1:0]       r_len, r_i, r_offl, r_offr;

    logic signed [ST_W-1:0]  r_rdl, r_rdr, r_px, r_py;
    logic signed [PRD_W-1:0] r_pxx, r_pyy, r_pxy;
    logic                    r_v1, r_v2;
    logic signed [ACC_W-1:0] r_sx, r_sy, r_sxx, r_syy, r_sxy;

    logic [2:0]              r_mi;
    logic signed [T_W-1:0]   r_term;
    logic signed [D_W-1:0]   r_cov, r_vx, r_vy;
    logic [MW-1:0]           r_mag;

    logic                        r_any;
    logic signed [tdoa_pkg::SCORE_W-1:0] r_best;
    logic signed [LW-1:0]        r_best_shift;

    logic                             r_out_valid;
    logic [tdoa_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                             r_out_found;

    tdoa_pkg::t_arith_ctl arith_ctl;
    tdoa_pkg::t_arith_sts arith_sts;
    logic [MW-1:0]        op_a, op_b;
    logic                 mul_neg;
    logic [P_W-1:0]       prod;
    logic [MW-1:0]        root;
    logic [tdoa_pkg::Q_W-1:0] quot;

    logic                   accept;
    logic signed [SW-1:0]   in_l, in_r;
    logic signed [ST_W-1:0] hp_l, hp_r;
    logic [CNT_W-1:0]       n1, len_c, base_l, base_r, addr_l, addr_r;
    logic signed [LW-1:0]   lag_abs;
    logic                   lag_last;
    logic [ACC_W-1:0]       abs_sx, abs_sy, abs_sxx, abs_syy, abs_sxy;
    logic signed [T_W-1:0]  prod_s;
    logic signed [D_W-1:0]  diff;
    logic [D_W-1:0]         abs_cov;
    logic [MW-1:0]          cov_t, mag_clip;
    logic signed [tdoa_pkg::SCORE_W-1:0] score;
    logic                   found;
    logic signed [tdoa_pkg::DELAY_W-1:0] delay_c;
    logic                   out_load;

    assign accept = i_s_tvalid && o_s_tready;
    assign in_l   = i_s_tdata[SW-1:0];
    assign in_r   = i_s_tdata[2*SW-1:SW];
    assign hp_l   = hp_filter(r_hp_alpha, in_l, r_prev_l);
    assign hp_r   = hp_filter(r_hp_alpha, in_r, r_prev_r);

    assign n1       = r_cnt - CNT_W'(1);
    assign lag_abs  = r_lag[LW-1] ? -r_lag : r_lag;
    assign len_c    = r_cnt - CNT_W'(lag_abs[LW-2:0]);
    assign base_l   = r_lag[LW-1] ? CNT_W'(lag_abs[LW-2:0]) : '0;
    assign base_r   = r_lag[LW-1] ? '0 : CNT_W'(lag_abs[LW-2:0]);
    assign addr_l   = r_offl + r_i;
    assign addr_r   = r_offr + r_i;
    assign lag_last = (r_lag == $signed({1'b0, r_bound}));

    assign abs_sx  = r_sx[ACC_W-1]  ? -r_sx  : r_sx;
    assign abs_sy  = r_sy[ACC_W-1]  ? -r_sy  : r_sy;
    assign abs_sxx = r_sxx[ACC_W-1] ? -r_sxx : r_sxx;
    assign abs_syy = r_syy[ACC_W-1] ? -r_syy : r_syy;
    assign abs_sxy = r_sxy[ACC_W-1] ? -r_sxy : r_sxy;

    always_comb begin
        op_a    = '0;
        op_b    = '0;
        mul_neg = 1'b0;
        if (r_state == S_DGO) begin
            op_a = mag_clip;
            op_b = root;
        end else begin
            case (r_mi)
                3'd0: begin
                    op_a    = MW'(r_len);
                    op_b    = MW'(abs_sxy);
                    mul_neg = r_sxy[ACC_W-1];
                end
                3'd1: begin
                    op_a    = MW'(abs_sx);
                    op_b    = MW'(abs_sy);
                    mul_neg = r_sx[ACC_W-1] ^ r_sy[ACC_W-1];
                end
                3'd2: begin
                    op_a    = MW'(r_len);
                    op_b    = MW'(abs_sxx);
                    mul_neg = r_sxx[ACC_W-1];
                end
                3'd3: begin
                    op_a = MW'(abs_sx);
                    op_b = MW'(abs_sx);
                end
                3'd4: begin
                    op_a    = MW'(r_len);
                    op_b    = MW'(abs_syy);
                    mul_neg = r_syy[ACC_W-1];
                end
                3'd5: begin
                    op_a = MW'(abs_sy);
                    op_b = MW'(abs_sy);
                end
                3'd6: begin
                    op_a = r_vx[MW-1:0];
                    op_b = r_vy[MW-1:0];
                end
                default: begin
                    op_a = '0;
                end
            endcase
        end
    end

    always_comb begin
        arith_ctl.start = 1'b0;
        arith_ctl.op    = tdoa_pkg::OP_MUL;
        case (r_state)
            S_MGO: begin
                arith_ctl.start = 1'b1;
            end
            S_SGO: begin
                arith_ctl.start = 1'b1;
                arith_ctl.op    = tdoa_pkg::OP_SQRT;
            end
            S_DGO: begin
                arith_ctl.start = 1'b1;
                arith_ctl.op    = tdoa_pkg::OP_DIV;
            end
            default: begin
                arith_ctl.start = 1'b0;
            end
        endcase
    end

    tdoa_arith #(
        .MUL_W (MW)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (arith_ctl),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_wide  (prod),
        .o_sts   (arith_sts),
        .o_prod  (prod),
        .o_root  (root),
        .o_quot  (quot)
    );

    assign prod_s   = mul_neg ? (T_W'(0) - T_W'(prod)) : T_W'(prod);
    assign diff     = {r_term[T_W-1], r_term} - {prod_s[T_W-1], prod_s};
    assign abs_cov  = r_cov[D_W-1] ? -r_cov : r_cov;
    assign cov_t    = abs_cov[MW-1:0];
    assign mag_clip = (r_mag > root) ? root : r_mag;
    assign score    = r_cov[D_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign found    = r_any && (r_best >= $signed({1'b0, r_min_corr}));
    assign delay_c  = r_best_shift * $signed({1'b0, r_period});
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (accept && i_s_tlast) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_cnt < CNT_W'(2)) ? S_FIN : S_LAG;
            end
            S_LAG: begin
                n_state = (CW'(len_c) < CW'(r_min_overlap)) ? S_NEXT : S_ACC;
            end
            S_ACC: begin
                if (r_i == r_len && !r_v1 && !r_v2) begin
                    n_state = S_MGO;
                end
            end
            S_MGO: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (arith_sts.done) begin
                    if (r_mi == 3'd5) begin
                        n_state = S_VCHK;
                    end else if (r_mi == 3'd6) begin
                        n_state = S_SGO;
                    end else begin
                        n_state = S_MGO;
                    end
                end
            end
            S_VCHK: begin
                if (r_vx[D_W-1] || r_vx == '0 || r_vy[D_W-1] || r_vy == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_MGO;
                end
            end
            S_SGO: begin
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (arith_sts.done) begin
                    n_state = (root == '0) ? S_NEXT : S_DGO;
                end
            end
            S_DGO: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (arith_sts.done) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = lag_last ? S_FIN : S_LAG;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_hp_alpha    <= tdoa_pkg::HP_ALPHA_RST;
            r_period      <= tdoa_pkg::SAMPLE_PERIOD_RST;
            r_max_lag     <= tdoa_pkg::MAX_LAG_RST;
            r_min_overlap <= tdoa_pkg::MIN_OVERLAP_RST;
            r_min_corr    <= tdoa_pkg::MIN_CORR_RST;
            r_prev_l      <= '0;
            r_prev_r      <= '0;
            r_cnt         <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_any         <= 1'b0;
            r_best_shift  <= '0;
            r_mi          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tdoa_pkg::REG_HP_ALPHA:      r_hp_alpha    <= i_cfg_data[tdoa_pkg::ALPHA_W-1:0];
                    tdoa_pkg::REG_SAMPLE_PERIOD: r_period      <= i_cfg_data[tdoa_pkg::PERIOD_W-1:0];
                    tdoa_pkg::REG_MAX_LAG:       r_max_lag     <= i_cfg_data[tdoa_pkg::MAXLAG_W-1:0];
                    tdoa_pkg::REG_MIN_OVERLAP:   r_min_overlap <= i_cfg_data[tdoa_pkg::MINOV_W-1:0];
                    tdoa_pkg::REG_MIN_CORR:      r_min_corr    <= i_cfg_data[tdoa_pkg::MINC_W-1:0];
                    default: begin
                        r_hp_alpha <= r_hp_alpha;
                    end
                endcase
            end

            if (accept && r_cnt < CNT_W'(MAX_SAMPLES)) begin
                r_prev_l <= in_l;
                r_prev_r <= in_r;
                r_cnt    <= r_cnt + CNT_W'(1);
            end

            r_v1 <= (r_state == S_ACC) && (r_i != r_len);
            r_v2 <= r_v1;

            case (r_state)
                S_START: begin
                    r_any        <= 1'b0;
                    r_best_shift <= '0;
                    if (CW'(n1) < CW'(r_max_lag)) begin
                        r_bound <= n1[tdoa_pkg::MAXLAG_W-1:0];
                        r_lag   <= -$signed({1'b0, n1[tdoa_pkg::MAXLAG_W-1:0]});
                    end else begin
                        r_bound <= r_max_lag;
                        r_lag   <= -$signed({1'b0, r_max_lag});
                    end
                end
                S_LAG: begin
                    r_len  <= len_c;
                    r_offl <= base_l;
                    r_offr <= base_r;
                    r_i    <= '0;
                    r_mi   <= '0;
                end
                S_ACC: begin
                    if (r_i != r_len) begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                S_MWAIT: begin
                    if (arith_sts.done) begin
                        case (r_mi)
                            3'd1:    r_cov  <= diff;
                            3'd3:    r_vx   <= diff;
                            3'd5:    r_vy   <= diff;
                            default: r_term <= prod_s;
                        endcase
                        if (r_mi != 3'd6) begin
                            r_mi <= r_mi + 3'd1;
                        end
                    end
                end
                S_SWAIT: begin
                    r_mag <= cov_t;
                end
                S_DWAIT: begin
                    if (arith_sts.done && (!r_any || score > r_best)) begin
                        r_any        <= 1'b1;
                        r_best       <= score;
                        r_best_shift <= r_lag;
                    end
                end
                S_NEXT: begin
                    r_lag <= r_lag + LW'(1);
                end
                S_FIN: begin
                    if (out_load) begin
                        r_cnt    <= '0;
                        r_prev_l <= '0;
                        r_prev_r <= '0;
                    end
                end
                default: begin
                    r_mi <= r_mi;
                end
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample stores, sum pipeline and output register
    always_ff @(posedge i_clk) begin
        if (accept && r_cnt < CNT_W'(MAX_SAMPLES)) begin
            r_left_mem[r_cnt[AW-1:0]]  <= hp_l;
            r_right_mem[r_cnt[AW-1:0]] <= hp_r;
        end
        r_rdl <= r_left_mem[addr_l[AW-1:0]];
        r_rdr <= r_right_mem[addr_r[AW-1:0]];
        r_px  <= r_rdl;
        r_py  <= r_rdr;
        r_pxx <= r_rdl * r_rdl;
        r_pyy <= r_rdr * r_rdr;
        r_pxy <= r_rdl * r_rdr;
        if (r_state == S_LAG) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (r_v2) begin
            r_sx  <= r_sx  + ACC_W'(r_px);
            r_sy  <= r_sy  + ACC_W'(r_py);
            r_sxx <= r_sxx + ACC_W'(r_pxx);
            r_syy <= r_syy + ACC_W'(r_pyy);
            r_sxy <= r_sxy + ACC_W'(r_pxy);
        end
        if (out_load) begin
            r_out_found <= found;
            if (found) begin
                r_out_data <= {1'b0, r_best[tdoa_pkg::CORR_W-1:0], delay_c, r_best_shift};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_found;

endmodule

>>> sv/tdoa_checker.sv
`include "tdoa_cross_correlation_unit_defines.svh"

module tdoa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tlast,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [tdoa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tuser
);

    `TDOA_ASSERT(a_search_holds_ready, i_clk, i_rst_n, (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
    `TDOA_ASSERT(a_miss_is_zero, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
    `TDOA_ASSERT(a_corr_range, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[tdoa_pkg::CORR_LSB +: tdoa_pkg::CORR_W] <= 16'd32768))
    `TDOA_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
    `TDOA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_m_tvalid && o_s_tready))

endmodule

bind tdoa_cross_correlation_unit tdoa_checker u_tdoa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

>>> sim/tdoa_cross_correlation_unit_test.sv
`timescale 1ns / 100ps

module tdoa_cross_correlation_unit_test;

    localparam int LAG_W       = tdoa_pkg::LAG_W;
    localparam int DELAY_W     = tdoa_pkg::DELAY_W;
    localparam int CORR_W      = tdoa_pkg::CORR_W;
    localparam int LAG_LSB     = tdoa_pkg::LAG_LSB;
    localparam int DELAY_LSB   = tdoa_pkg::DELAY_LSB;
    localparam int CORR_LSB    = tdoa_pkg::CORR_LSB;
    localparam int OUT_TDATA_W = tdoa_pkg::OUT_TDATA_W;
    localparam int IDX_W       = tdoa_pkg::IDX_W;
    localparam int CFG_W       = tdoa_pkg::CFG_W;

    localparam int N_SLOTS   = 4096;
    localparam int CYC_LIMIT = 8000000;
    localparam int K_NOISE   = 0;
    localparam int K_SHIFT   = 1;
    localparam int K_NEG     = 2;
    localparam int K_FLAT    = 3;
    localparam int K_EXTREME = 4;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } t_pair;

    typedef struct {
        logic                      found;
        logic signed [LAG_W-1:0]   lag;
        logic [DELAY_W-1:0]        delay;
        logic [CORR_W-1:0]         corr;
    } t_tdoa;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [31:0]            i_s_tdata = '0;
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    tdoa_cross_correlation_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_pair  pending_pairs[$];
    t_tdoa  expected_delays[$];
    t_pair  cur_pair;
    int     errors = 0;
    int     cycles = 0;
    int     send_gap = 0;
    int     recv_stall = 0;
    int     results_seen = 0;
    int     pairs_queued = 0;
    bit     burst = 0;

    // predictor state
    longint      left_filt[N_SLOTS];
    longint      right_filt[N_SLOTS];
    longint      prev_l, prev_r;
    int          pair_cnt;
    logic [15:0] alpha;
    logic [27:0] period;
    logic [11:0] lag_limit;
    logic [12:0] overlap_min;
    logic [15:0] corr_min;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic longint highpass(input longint x, input longint prev);
        longint p, mag, y;
        p = longint'(alpha) * (x - prev);
        mag = p < 0 ? -p : p;
        y = (mag + 32768) >>> 16;
        return p < 0 ? -y : y;
    endfunction

    function automatic logic [127:0] root_of_product(input longint a, input longint b);
        logic [127:0] prod, lo, hi, mid;
        prod = 128'(a) * 128'(b);
        lo = 0;
        hi = 128'(1) << 58;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            if (mid * mid <= prod) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_tdoa search_delay();
        t_tdoa        res;
        int           n, b, lag, len, sl, sr, i, s, best_s, best_lag;
        bit           any;
        longint       sx, sy, sxx, syy, sxy, x, y, cov, vx, vy, d;
        logic [127:0] r, mag;
        res = '{1'b0, '0, '0, '0};
        n = pair_cnt;
        any = 0;
        best_s = -65536;
        best_lag = 0;
        if (n < 2) return res;
        b = int'(lag_limit);
        if (b > n - 1) b = n - 1;
        for (lag = -b; lag <= b; lag++) begin
            sl = lag < 0 ? -lag : 0;
            sr = lag > 0 ? lag : 0;
            len = n - (lag < 0 ? -lag : lag);
            if (len < int'(overlap_min)) continue;
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
            for (i = 0; i < len; i++) begin
                x = left_filt[sl + i];
                y = right_filt[sr + i];
                sx += x; sy += y;
                sxx += x * x; syy += y * y; sxy += x * y;
            end
            cov = longint'(len) * sxy - sx * sy;
            vx = longint'(len) * sxx - sx * sx;
            vy = longint'(len) * syy - sy * sy;
            if (vx <= 0 || vy <= 0) continue;
            r = root_of_product(vx, vy);
            if (r == 0) continue;
            mag = 128'(cov < 0 ? -cov : cov);
            if (mag > r) mag = r;
            s = int'((mag * 32768) / r);
            if (cov < 0) s = -s;
            if (!any || s > best_s) begin
                any = 1;
                best_s = s;
                best_lag = lag;
            end
        end
        if (any && best_s >= int'(corr_min)) begin
            d = longint'(best_lag) * longint'(period);
            res.found = 1'b1;
            res.lag = LAG_W'(best_lag);
            res.delay = d[DELAY_W-1:0];
            res.corr = CORR_W'(best_s);
        end
        return res;
    endfunction

    task automatic predict_pair(input t_pair p);
        longint l, r;
        l = longint'($signed(p.left));
        r = longint'($signed(p.right));
        if (pair_cnt < N_SLOTS) begin
            left_filt[pair_cnt] = highpass(l, prev_l);
            right_filt[pair_cnt] = highpass(r, prev_r);
            prev_l = l;
            prev_r = r;
            pair_cnt++;
        end
        if (p.last) begin
            expected_delays.push_back(search_delay());
            pair_cnt = 0;
            prev_l = 0;
            prev_r = 0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) predict_pair(cur_pair);
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    cur_pair = pending_pairs.pop_front();
                    i_s_tdata <= {cur_pair.right, cur_pair.left};
                    i_s_tlast <= cur_pair.last;
                    i_s_tvalid <= 1'b1;
                    send_gap = burst ? 0 : $urandom_range(0, 10);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_tdoa want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_delays.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = expected_delays.pop_front();
                    if (o_m_tuser !== want.found)
                        report($sformatf("found %b want %b", o_m_tuser, want.found));
                    if (o_m_tdata[LAG_LSB +: LAG_W] !== want.lag)
                        report($sformatf("lag %0d want %0d",
                            $signed(o_m_tdata[LAG_LSB +: LAG_W]), want.lag));
                    if (o_m_tdata[DELAY_LSB +: DELAY_W] !== want.delay)
                        report($sformatf("delay %h want %h",
                            o_m_tdata[DELAY_LSB +: DELAY_W], want.delay));
                    if (o_m_tdata[CORR_LSB +: CORR_W] !== want.corr)
                        report($sformatf("corr %0d want %0d",
                            o_m_tdata[CORR_LSB +: CORR_W], want.corr));
                end
                results_seen++;
                recv_stall = burst ? 0 : $urandom_range(0, 10);
                // long hold-off so the block backs up while pairs keep coming
                if (results_seen == 3) recv_stall = 2500;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            i_m_tready <= (recv_stall == 0);
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        case (idx)
            tdoa_pkg::REG_HP_ALPHA:      alpha = 16'(val);
            tdoa_pkg::REG_SAMPLE_PERIOD: period = 28'(val);
            tdoa_pkg::REG_MAX_LAG:       lag_limit = 12'(val);
            tdoa_pkg::REG_MIN_OVERLAP:   overlap_min = 13'(val);
            tdoa_pkg::REG_MIN_CORR:      corr_min = 16'(val);
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned a, input int unsigned p, input int unsigned ml,
                              input int unsigned mo, input int unsigned mc);
        write_reg(tdoa_pkg::REG_HP_ALPHA, a);
        write_reg(tdoa_pkg::REG_SAMPLE_PERIOD, p);
        write_reg(tdoa_pkg::REG_MAX_LAG, ml);
        write_reg(tdoa_pkg::REG_MIN_OVERLAP, mo);
        write_reg(tdoa_pkg::REG_MIN_CORR, mc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        logic [15:0] v;
        v = 16'($urandom());
        return 16'($signed(v) >>> $urandom_range(0, 12));
    endfunction

    task automatic add_capture(input int n, input int kind, input int shift);
        logic [15:0] base[$];
        t_pair       p;
        int          i;
        for (i = 0; i < n + 16; i++) base.push_back(rand_sample());
        for (i = 0; i < n; i++) begin
            p.left = base[i + 8];
            case (kind)
                K_SHIFT: p.right = base[i + 8 - shift];
                K_NEG:   p.right = (p.left == 16'h8000) ? 16'h7fff : -p.left;
                K_FLAT:  p.right = '0;
                K_EXTREME: begin
                    p.left = i[0] ? 16'h8000 : 16'h7fff;
                    p.right = i[1] ? 16'h7fff : 16'h8000;
                end
                default: p.right = rand_sample();
            endcase
            p.last = (i == n - 1);
            pending_pairs.push_back(p);
        end
        pairs_queued += n;
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && !i_s_tvalid && expected_delays.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int k, c;
        alpha = tdoa_pkg::HP_ALPHA_RST;
        period = tdoa_pkg::SAMPLE_PERIOD_RST;
        lag_limit = tdoa_pkg::MAX_LAG_RST;
        overlap_min = tdoa_pkg::MIN_OVERLAP_RST;
        corr_min = tdoa_pkg::MIN_CORR_RST;
        pair_cnt = 0;
        prev_l = 0;
        prev_r = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: short captures
        add_capture(1, K_NOISE, 0);
        add_capture(3, K_SHIFT, 1);
        drain();

        set_config(65535, 268435455, 4095, 0, 0);
        add_capture(2, K_NOISE, 0);
        add_capture(8, K_EXTREME, 0);
        add_capture(5, K_FLAT, 0);
        add_capture(6, K_NEG, 0);
        add_capture(7, K_SHIFT, -3);
        drain();

        set_config(0, 1, 0, 4096, 32768);
        add_capture(4, K_NOISE, 0);
        drain();

        set_config(40000, 12345, 3, 2, 65535);
        add_capture(9, K_SHIFT, 2);
        drain();

        while (pairs_queued < 1100) begin
            c = $urandom_range(0, 9);
            set_config($urandom_range(0, 65535), $urandom_range(1, 268435455),
                       $urandom_range(0, 6), $urandom_range(1, 12),
                       c == 0 ? 65535 : $urandom_range(0, 32768));
            burst = ($urandom_range(0, 3) == 0);
            for (k = $urandom_range(3, 6); k > 0; k--) begin
                c = $urandom_range(0, 9);
                add_capture($urandom_range(1, 24),
                            c < 6 ? K_SHIFT : (c < 8 ? K_NOISE : (c < 9 ? K_NEG : K_FLAT)),
                            $urandom_range(0, 12) - 6);
            end
            drain();
        end
        burst = 0;

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/tdoa_pkg.sv
sv/tdoa_arith.sv
sv/tdoa_cross_correlation_unit.sv
sv/tdoa_checker.sv
sim/tdoa_cross_correlation_unit_test.sv
